>>> rtl/core/tasr_pkg.sv
// ----------------------------------------------------------------------------
// Two-axis ramp generator package
// Shared constants, configuration register indexes and the control record
// that the sequencer hands to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package tasr_pkg;

  localparam int POS_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RATE_W        = 20;
  localparam int ELAPSED_W     = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int US_PER_S      = 1000000;
  localparam int DIST_CAP_LOG2 = 60;

  localparam logic [RATE_W-1:0] LIMIT_RST = RATE_W'(50000);
  localparam logic [RATE_W-1:0] ACCEL_RST = RATE_W'(100000);
  localparam logic [RATE_W-1:0] BRAKE_RST = RATE_W'(50000);

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_PITCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_YAW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_YAW   = 3'd5;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_ctl_t;

endpackage

>>> rtl/core/tasr_if.sv
// ----------------------------------------------------------------------------
// Two-axis ramp generator channels
// Valid/ready channels for tick requests and step results.
// ----------------------------------------------------------------------------
interface tasr_in_if import tasr_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ELAPSED_W-1:0]       elapsed_us;
  logic signed [POS_BITS-1:0] target_pitch;
  logic signed [POS_BITS-1:0] target_yaw;

  modport source (output valid, elapsed_us, target_pitch, target_yaw, input ready);
  modport sink   (input valid, elapsed_us, target_pitch, target_yaw, output ready);
endinterface

interface tasr_out_if import tasr_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       pulse_pitch;
  logic                       forward_pitch;
  logic                       pulse_yaw;
  logic                       forward_yaw;
  logic signed [POS_BITS-1:0] count_pitch;
  logic signed [POS_BITS-1:0] count_yaw;

  modport source (output valid, pulse_pitch, forward_pitch, pulse_yaw, forward_yaw,
                  count_pitch, count_yaw, input ready);
  modport sink   (input valid, pulse_pitch, forward_pitch, pulse_yaw, forward_yaw,
                  count_pitch, count_yaw, output ready);
endinterface

>>> rtl/core/tasr_alu.sv
// ----------------------------------------------------------------------------
// Shared serial arithmetic unit
// Shift-add multiplier and restoring divider that share one shift register and
// one step counter; done pulses for one cycle when the result is ready.
// ----------------------------------------------------------------------------
module tasr_alu import tasr_pkg::*; #(
  parameter int W = POS_BITS_DEF + FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  alu_ctl_t         ctl,
  input  logic [2*W-1:0]   x,
  input  logic [W-1:0]     y,
  output logic             done,
  output logic [2*W-1:0]   res
);

  localparam int P2   = 2 * W;
  localparam int CNTW = $clog2(P2 + 1);

  logic [P2-1:0]   a_r;
  logic [P2-1:0]   acc_r;
  logic [W-1:0]    b_r;
  logic [W-1:0]    rem_r;
  logic            op_r;
  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [W:0]      sh;
  logic [W:0]      diff;
  logic            ge;

  assign sh   = {rem_r, a_r[P2-1]};
  assign diff = sh - {1'b0, b_r};
  assign ge   = (sh >= {1'b0, b_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (ctl.op == OP_MUL) ? CNTW'(W) : CNTW'(P2);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= x;
      b_r   <= y;
      acc_r <= '0;
      rem_r <= '0;
      op_r  <= ctl.op;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r <= {a_r[P2-2:0], 1'b0};
        b_r <= {1'b0, b_r[W-1:1]};
      end else begin
        rem_r <= ge ? diff[W-1:0] : sh[W-1:0];
        a_r   <= {a_r[P2-2:0], ge};
      end
    end
  end

  assign done = done_r;
  assign res  = (op_r == OP_MUL) ? acc_r : a_r;

endmodule

>>> rtl/core/two_axis_stepper_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// Two-axis stepper ramp generator
// Per tick request, each axis integrates its ideal position, issues at most
// one step and then brakes, accelerates or holds its speed after a stopping-distance test.
//
// Channel  Direction  Handshake     Contents
// in_req   sink       valid/ready   elapsed_us, target_pitch, target_yaw
// out_res  source     valid/ready   pulse, forward and count for both axes
// cfg_*    sink       write enable  register index and 20-bit value
//
// AW is the width of the shared unit (POS_BITS+FRAC_BITS+11 at the default
// widths). Per axis the unit runs five serial multiplies, two of which divide
// by one million through a reciprocal, and one restoring divide by the brake
// rate. in_req is ready only while the sequencer is idle. The result sits in
// an output register, so a stalled out_res only holds the sequencer when a
// second result is finished. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module two_axis_stepper_ramp_generator_top import tasr_pkg::*; #(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tasr_in_if.sink               in_req,
  tasr_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RATE_W-1:0]     cfg_wdata
);

  localparam int PW = POS_BITS + FRAC_BITS;
  localparam int P2 = 2 * PW;
  localparam int CW = ((P2 > DIST_CAP_LOG2) ? P2 : DIST_CAP_LOG2) + 3;

  // Division by one million: the dividend is first shifted right by six,
  // then multiplied by a rounded-up reciprocal of 15625.
  localparam int XW_POS    = PW + ELAPSED_W;
  localparam int XW_RATE   = RATE_W + ELAPSED_W + FRAC_BITS;
  localparam int XW        = (XW_POS > XW_RATE) ? XW_POS : XW_RATE;
  localparam int RCP_PRE   = 6;
  localparam int RCP_D     = US_PER_S >> RCP_PRE;
  localparam int NW        = XW - RCP_PRE;
  localparam int RCP_K     = NW + 14;
  localparam int AW        = NW + 1;
  localparam int AP2       = 2 * AW;

  localparam logic [RCP_K:0] RCP_POW = {1'b1, {RCP_K{1'b0}}};
  localparam logic [RCP_K:0] RCP_M   =
    (RCP_POW + (RCP_K+1)'(RCP_D - 1)) / (RCP_K+1)'(RCP_D);

  localparam logic signed [CW-1:0] ONE_W = 1;
  localparam logic signed [CW-1:0] PMAX  = {{(CW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [CW-1:0] PMIN  = ~PMAX;
  localparam logic signed [CW-1:0] DCAP  = ONE_W <<< DIST_CAP_LOG2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_RCP1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_MUL3 = 3'd5;
  localparam logic [2:0] S_RCP3 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                 state_r;
  logic                       ax_r;
  logic                       start_r;
  logic                       brk_r;
  logic                       acc_ok_r;
  logic [RATE_W-1:0]          limit_r [2];
  logic [RATE_W-1:0]          accel_r [2];
  logic [RATE_W-1:0]          brake_r [2];
  logic [ELAPSED_W-1:0]       e_r;
  logic signed [POS_BITS-1:0] goal_r [2];
  logic signed [PW-1:0]       pos_r [2];
  logic signed [PW-1:0]       spd_r [2];
  logic signed [POS_BITS-1:0] cnt_r [2];
  logic [1:0]                 pulse_r;
  logic [1:0]                 fwd_r;
  logic                       out_valid_r;
  logic                       o_pulse_p_r, o_fwd_p_r, o_pulse_y_r, o_fwd_y_r;
  logic signed [POS_BITS-1:0] o_cnt_p_r, o_cnt_y_r;

  alu_ctl_t                   alu_ctl;
  logic [AP2-1:0]             alu_x;
  logic [AW-1:0]              alu_y;
  logic                       alu_done;
  logic [AP2-1:0]             alu_res;

  logic signed [PW-1:0]       sp;
  logic                       dir_fwd;
  logic [PW-1:0]              m;
  logic [RATE_W-1:0]          b_eff;
  logic signed [CW-1:0]       res_w, quo_w, pos_w, sp_w, cnt_w, goal_w, m_w, lim_w;
  logic signed [CW-1:0]       psum, npos_w, up_th, cnt1, dn_th, cnt2;
  logic                       up, dn;
  logic signed [CW-1:0]       dq, stop_len, dpos, target, nsp, nsp_sat;
  logic                       brk_now, acc_ok_now;

  assign sp      = spd_r[ax_r];
  assign dir_fwd = (sp > 0);
  assign m       = sp[PW-1] ? (~sp + PW'(1)) : sp;
  assign b_eff   = (brake_r[ax_r] == '0) ? RATE_W'(1) : brake_r[ax_r];

  assign res_w  = CW'(alu_res);
  assign quo_w  = CW'(alu_res >> RCP_K);
  assign pos_w  = {{(CW-PW){pos_r[ax_r][PW-1]}}, pos_r[ax_r]};
  assign sp_w   = {{(CW-PW){sp[PW-1]}}, sp};
  assign cnt_w  = {{(CW-POS_BITS){cnt_r[ax_r][POS_BITS-1]}}, cnt_r[ax_r]};
  assign goal_w = {{(CW-POS_BITS){goal_r[ax_r][POS_BITS-1]}}, goal_r[ax_r]};
  assign m_w    = {{(CW-PW){1'b0}}, m};
  assign lim_w  = {{(CW-RATE_W){1'b0}}, limit_r[ax_r]};

  always_comb begin
    psum   = sp[PW-1] ? (pos_w - quo_w) : (pos_w + quo_w);
    npos_w = (psum > PMAX) ? PMAX : ((psum < PMIN) ? PMIN : psum);
    up_th  = (cnt_w + ONE_W) <<< FRAC_BITS;
    up     = (npos_w > up_th);
    cnt1   = up ? (cnt_w + ONE_W) : cnt_w;
    dn_th  = (cnt1 - ONE_W) <<< FRAC_BITS;
    dn     = (npos_w < dn_th);
    cnt2   = dn ? (cnt1 - ONE_W) : cnt1;

    dq         = res_w >>> (FRAC_BITS + 1);
    stop_len   = (dq > DCAP) ? DCAP : dq;
    dpos       = dir_fwd ? (pos_w + stop_len) : (pos_w - stop_len);
    target     = goal_w <<< FRAC_BITS;
    brk_now    = dir_fwd ? (dpos >= target) : (dpos <= target);
    acc_ok_now = (m_w < (lim_w <<< FRAC_BITS));

    if (brk_r) begin
      nsp = dir_fwd ? (sp_w - quo_w) : (sp_w + quo_w);
    end else if (acc_ok_r) begin
      nsp = dir_fwd ? (sp_w + quo_w) : (sp_w - quo_w);
    end else begin
      nsp = sp_w;
    end
    nsp_sat = (nsp > PMAX) ? PMAX : ((nsp < PMIN) ? PMIN : nsp);
  end

  always_comb begin
    alu_ctl.start = start_r;
    alu_ctl.op    = OP_MUL;
    alu_x         = '0;
    alu_y         = '0;
    case (state_r)
      S_MUL1: begin
        alu_x = AP2'(m);
        alu_y = AW'(e_r);
      end
      S_RCP1, S_RCP3: begin
        alu_x = AP2'(RCP_M);
        alu_y = AW'(alu_res >> RCP_PRE);
      end
      S_MUL2: begin
        alu_x = AP2'(m);
        alu_y = AW'(m);
      end
      S_DIV2: begin
        alu_ctl.op = OP_DIV;
        alu_x      = alu_res;
        alu_y      = AW'(b_eff);
      end
      S_MUL3: begin
        alu_x = AP2'(brk_r ? b_eff : accel_r[ax_r]) << FRAC_BITS;
        alu_y = AW'(e_r);
      end
      default: begin
        alu_ctl.op = OP_MUL;
      end
    endcase
  end

  tasr_alu #(
    .W (AW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .x     (alu_x),
    .y     (alu_y),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= LIMIT_RST;
      limit_r[1] <= LIMIT_RST;
      accel_r[0] <= ACCEL_RST;
      accel_r[1] <= ACCEL_RST;
      brake_r[0] <= BRAKE_RST;
      brake_r[1] <= BRAKE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT_PITCH: limit_r[0] <= cfg_wdata;
        CFG_LIMIT_YAW:   limit_r[1] <= cfg_wdata;
        CFG_ACCEL_PITCH: accel_r[0] <= cfg_wdata;
        CFG_ACCEL_YAW:   accel_r[1] <= cfg_wdata;
        CFG_BRAKE_PITCH: brake_r[0] <= cfg_wdata;
        CFG_BRAKE_YAW:   brake_r[1] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      spd_r[0]    <= '0;
      spd_r[1]    <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
    end else begin
      start_r <= 1'b0;
      if ((state_r == S_OUT) && (!out_valid_r || out_res.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            e_r       <= in_req.elapsed_us;
            goal_r[0] <= in_req.target_pitch;
            goal_r[1] <= in_req.target_yaw;
            ax_r      <= 1'b0;
            start_r   <= 1'b1;
            state_r   <= S_MUL1;
          end
        end
        S_MUL1, S_MUL2, S_MUL3: begin
          if (alu_done) begin
            start_r <= 1'b1;
            state_r <= state_r + 3'd1;
          end
        end
        S_RCP1: begin
          if (alu_done) begin
            pos_r[ax_r]   <= npos_w[PW-1:0];
            cnt_r[ax_r]   <= cnt2[POS_BITS-1:0];
            pulse_r[ax_r] <= up | dn;
            fwd_r[ax_r]   <= up & ~dn;
            start_r       <= 1'b1;
            state_r       <= S_MUL2;
          end
        end
        S_DIV2: begin
          if (alu_done) begin
            brk_r    <= brk_now;
            acc_ok_r <= acc_ok_now;
            start_r  <= 1'b1;
            state_r  <= S_MUL3;
          end
        end
        S_RCP3: begin
          if (alu_done) begin
            spd_r[ax_r] <= nsp_sat[PW-1:0];
            if (!ax_r) begin
              ax_r    <= 1'b1;
              start_r <= 1'b1;
              state_r <= S_MUL1;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_res.ready) begin
            o_pulse_p_r <= pulse_r[0];
            o_fwd_p_r   <= fwd_r[0];
            o_pulse_y_r <= pulse_r[1];
            o_fwd_y_r   <= fwd_r[1];
            o_cnt_p_r   <= cnt_r[0];
            o_cnt_y_r   <= cnt_r[1];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.pulse_pitch   = o_pulse_p_r;
  assign out_res.forward_pitch = o_fwd_p_r;
  assign out_res.pulse_yaw     = o_pulse_y_r;
  assign out_res.forward_yaw   = o_fwd_y_r;
  assign out_res.count_pitch   = o_cnt_p_r;
  assign out_res.count_yaw     = o_cnt_y_r;

endmodule

>>> tb/sv/two_axis_stepper_ramp_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-axis stepper ramp generator testbench
// Drives tick requests with random gaps and checks every step result against
// an in-bench motion profile model or a directed expected result, across several register settings.
// ----------------------------------------------------------------------------
module two_axis_stepper_ramp_generator_top_tb;
  import tasr_pkg::*;

  localparam longint ONE_STEP = 64'sd65536;
  localparam longint POS_MAX  = (64'sd1 <<< 39) - 1;
  localparam longint POS_MIN  = -(64'sd1 <<< 39);
  localparam int     IDLE_LIMIT = 40000;
  localparam int     DRAIN_CYCLES = 2000;

  typedef struct {
    bit                 pulse_p;
    bit                 fwd_p;
    bit                 pulse_y;
    bit                 fwd_y;
    logic signed [23:0] cnt_p;
    logic signed [23:0] cnt_y;
  } step_res_t;

  typedef struct {
    logic [15:0]        elapsed;
    logic signed [23:0] goal_p;
    logic signed [23:0] goal_y;
    bit                 typed;
    step_res_t          res;
  } tick_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0] cfg_wdata;

  tasr_in_if  in_if();
  tasr_out_if out_if();

  two_axis_stepper_ramp_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  longint    lim_q[2];
  longint    acc_q[2];
  longint    brk_q[2];
  longint    pos_q[2];
  longint    spd_q[2];
  longint    cnt_q[2];
  step_res_t pending_steps[$];
  tick_t     cur_tick;
  int        errors;
  int        idle_cycles;
  bit        hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void advance_axis(int k, longint e, longint goal,
                                       output bit pulse, output bit fwd);
    longint sp, pos, cnt, dir, m, b, stop_len, dpos, target, delta;
    logic [127:0] sq;
    sp = spd_q[k];
    pos = pos_q[k];
    cnt = cnt_q[k];
    pos = clamp_pos(pos + (sp / 1000000) * e + ((sp % 1000000) * e) / 1000000);
    pulse = 1'b0;
    fwd = 1'b0;
    if (pos > (cnt + 1) * ONE_STEP) begin
      pulse = 1'b1;
      fwd = 1'b1;
      cnt++;
    end
    if (pos < (cnt - 1) * ONE_STEP) begin
      pulse = 1'b1;
      fwd = 1'b0;
      cnt--;
    end
    dir = (sp > 0) ? 1 : -1;
    m = (sp < 0) ? -sp : sp;
    b = (brk_q[k] != 0) ? brk_q[k] : 1;
    sq = 128'(m) * 128'(m);
    sq = (sq / 128'(b)) >> 17;
    stop_len = (sq > (128'd1 << 60)) ? (64'sd1 <<< 60) : longint'(sq[63:0]);
    dpos = (dir > 0) ? pos + stop_len : pos - stop_len;
    target = goal * ONE_STEP;
    if ((dir > 0) ? (dpos >= target) : (dpos <= target)) begin
      delta = ((b * e) <<< 16) / 1000000;
      sp = sp - dir * delta;
    end else if (m < (lim_q[k] <<< 16)) begin
      delta = ((acc_q[k] * e) <<< 16) / 1000000;
      sp = sp + dir * delta;
    end
    pos_q[k] = pos;
    spd_q[k] = clamp_pos(sp);
    cnt_q[k] = cnt;
  endfunction

  function automatic step_res_t predict_tick(tick_t t);
    step_res_t r;
    advance_axis(0, longint'(t.elapsed), longint'(t.goal_p), r.pulse_p, r.fwd_p);
    advance_axis(1, longint'(t.elapsed), longint'(t.goal_y), r.pulse_y, r.fwd_y);
    r.cnt_p = cnt_q[0][23:0];
    r.cnt_y = cnt_q[1][23:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    step_res_t want;
    step_res_t got;
    bit moved;
    if (rst_n) begin
      moved = (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready);
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        want = predict_tick(cur_tick);
        pending_steps.push_back(cur_tick.typed ? cur_tick.res : want);
      end
      if (out_if.valid && out_if.ready) begin
        got.pulse_p = out_if.pulse_pitch;
        got.fwd_p = out_if.forward_pitch;
        got.pulse_y = out_if.pulse_yaw;
        got.fwd_y = out_if.forward_yaw;
        got.cnt_p = out_if.count_pitch;
        got.cnt_y = out_if.count_yaw;
        if (pending_steps.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = pending_steps.pop_front();
          if (got.pulse_p !== want.pulse_p) report("pulse_pitch", got.pulse_p, want.pulse_p);
          if (got.fwd_p !== want.fwd_p) report("forward_pitch", got.fwd_p, want.fwd_p);
          if (got.pulse_y !== want.pulse_y) report("pulse_yaw", got.pulse_y, want.pulse_y);
          if (got.fwd_y !== want.fwd_y) report("forward_yaw", got.fwd_y, want.fwd_y);
          if (got.cnt_p !== want.cnt_p) report("count_pitch", got.cnt_p, want.cnt_p);
          if (got.cnt_y !== want.cnt_y) report("count_yaw", got.cnt_y, want.cnt_y);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("two_axis_stepper_ramp_generator_top_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // The receiver side: random gaps, one long hold-off that fills the block.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (6000) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = pick_gap();
      if (gap == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LIMIT_PITCH: lim_q[0] = val;
      CFG_LIMIT_YAW:   lim_q[1] = val;
      CFG_ACCEL_PITCH: acc_q[0] = val;
      CFG_ACCEL_YAW:   acc_q[1] = val;
      CFG_BRAKE_PITCH: brk_q[0] = val;
      CFG_BRAKE_YAW:   brk_q[1] = val;
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_all(logic [RATE_W-1:0] lim, logic [RATE_W-1:0] acc,
                           logic [RATE_W-1:0] brk);
    wait_quiet();
    write_reg(CFG_LIMIT_PITCH, lim);
    write_reg(CFG_LIMIT_YAW, lim);
    write_reg(CFG_ACCEL_PITCH, acc);
    write_reg(CFG_ACCEL_YAW, acc);
    write_reg(CFG_BRAKE_PITCH, brk);
    write_reg(CFG_BRAKE_YAW, brk);
  endtask

  task automatic send_tick(tick_t t);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_tick = t;
    in_if.valid <= 1'b1;
    in_if.elapsed_us <= t.elapsed;
    in_if.target_pitch <= t.goal_p;
    in_if.target_yaw <= t.goal_y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] pick_goal(int k);
    if ($urandom_range(0, 99) < 80)
      return 24'(cnt_q[k] + $signed($urandom_range(0, 800)) - 400);
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 16'($urandom_range(500, 20000));
    if (roll < 85) return 16'($urandom);
    return 16'($urandom_range(0, 100));
  endfunction

  task automatic random_ticks(int n);
    tick_t t;
    t.typed = 1'b0;
    for (int i = 0; i < n; i++) begin
      t.elapsed = pick_elapsed();
      t.goal_p = pick_goal(0);
      t.goal_y = pick_goal(1);
      send_tick(t);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    tick_t plan[$];
    tick_t t;
    step_res_t quiet;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.elapsed_us = '0;
    in_if.target_pitch = '0;
    in_if.target_yaw = '0;
    errors = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    for (int k = 0; k < 2; k++) begin
      lim_q[k] = 50000;
      acc_q[k] = 100000;
      brk_q[k] = 50000;
      pos_q[k] = 0;
      spd_q[k] = 0;
      cnt_q[k] = 0;
    end
    quiet = '{1'b0, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0};
    // Directed ticks: a zero tick right after reset leaves everything at rest.
    plan.push_back('{16'd0, 24'sd0, 24'sd0, 1'b1, quiet});
    plan.push_back('{16'd0, 24'sh7FFFFF, 24'sh800000, 1'b1, quiet});
    plan.push_back('{16'hFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0, quiet});
    plan.push_back('{16'hFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0, quiet});
    plan.push_back('{16'hFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0, quiet});
    for (int i = 0; i < 8; i++) plan.push_back('{16'd40000, 24'sd300, -24'sd300, 1'b0, quiet});
    for (int i = 0; i < 6; i++) plan.push_back('{16'd40000, 24'sd0, 24'sd0, 1'b0, quiet});
    plan.push_back('{16'd1, 24'sd5, -24'sd5, 1'b0, quiet});
    plan.push_back('{16'hFFFF, 24'sd0, 24'sd0, 1'b0, quiet});
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i]) send_tick(plan[i]);
    in_if.valid <= 1'b0;
    random_ticks(300);
    hold_off = 1'b1;
    random_ticks(100);
    write_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    random_ticks(350);
    write_all(20'd0, 20'd0, 20'd1);
    random_ticks(150);
    write_all(20'd2000, 20'd500000, 20'd1);
    random_ticks(350);
    write_all(20'd200000, 20'd3000, 20'd800000);
    random_ticks(300);
    wait_quiet();
    for (int j = 0; j < 6; j++) write_reg(CFG_IDX_W'(j), RATE_W'($urandom_range(1, 1048575)));
    random_ticks(380);
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("two_axis_stepper_ramp_generator_top_tb OK");
    end else begin
      $display("two_axis_stepper_ramp_generator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
